// ----- design/erwq_pkg.sv -----
// ----------------------------------------------------------------------------
// erwq_pkg
// Shared types and constants for the earliest-ready worker queue.
// ----------------------------------------------------------------------------
package erwq_pkg;

    // Default pool size
    localparam int NUM_WORKERS_DEF = 1024;

    // Fixed field widths
    localparam int TIME_W   = 32;
    localparam int WORKER_W = 10;

    // Input item kinds
    localparam logic KIND_INIT   = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,   // sweep both memories to their initial contents
        ST_IDLE,    // wait for an item
        ST_HLINK,   // successor of the head arrives
        ST_CMP,     // compare one visited worker, read the next
        ST_LPREV,   // link predecessor to the old head
        ST_LHEAD,   // link old head to the stop point
        ST_HREAD,   // read ready time of the head
        ST_HOUT     // hand the result to the output register
    } erwq_state_t;

endpackage

// ----- design/erwq_ram.sv -----
// ----------------------------------------------------------------------------
// erwq_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module erwq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/earliest_ready_worker_queue_top.sv -----
// ----------------------------------------------------------------------------
// earliest_ready_worker_queue_top
// Pool of workers kept as a linked list sorted by ready time, then number.
// ----------------------------------------------------------------------------
// Ready times and successor links sit in two RAMs of NUM_WORKERS entries.
// After reset a clearing pass over every entry fills them (every worker
// ready at 0, linked in number order); s_tready stays low meanwhile, while
// cfg writes are taken at any time. An initialize item (tuser 0) runs the same
// pass with start_minutes and then answers. An update item (tuser 1) rewrites
// the head's time and walks the list one link per cycle from the head's
// successor; when the head moves, the predecessor and the old head are
// relinked before the new head's time is read. The walk is bound by the
// single read port of each RAM. Every item yields one result on the master
// side; a new item is taken while that result waits there.
// ----------------------------------------------------------------------------
module earliest_ready_worker_queue_top
    #(
        parameter int NUM_WORKERS = erwq_pkg::NUM_WORKERS_DEF
    )
    (
        input  logic        clk,
        input  logic        rst_n,
        // configuration: start_minutes
        input  logic        cfg_we,
        input  logic [31:0] cfg_wdata,
        // input items
        input  logic        s_tvalid,
        output logic        s_tready,
        input  logic [31:0] s_tdata,   // [31:0] new_ready_minutes
        input  logic [0:0]  s_tuser,   // [0] kind
        // result items
        output logic        m_tvalid,
        input  logic        m_tready,
        output logic [47:0] m_tdata    // [9:0] head_worker, [41:10] head_ready_minutes
    );

    import erwq_pkg::*;

    localparam int AW = $clog2(NUM_WORKERS);
    localparam int LW = AW + 1;
    localparam logic [LW-1:0] LINK_NULL = LW'(NUM_WORKERS);
    localparam logic [AW-1:0] LAST_IDX  = AW'(NUM_WORKERS - 1);

    erwq_state_t state_reg, state_next;

    logic [TIME_W-1:0]   start_reg;
    logic [TIME_W-1:0]   sweep_val_reg, sweep_val_next;
    logic [AW-1:0]       sweep_idx_reg, sweep_idx_next;
    logic                init_out_reg, init_out_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [TIME_W-1:0]   when_reg, when_next;
    logic [LW-1:0]       cur_reg, cur_next;
    logic [LW-1:0]       prev_reg, prev_next;
    logic [LW-1:0]       hsucc_reg, hsucc_next;
    logic                out_valid_reg, out_valid_next;
    logic [WORKER_W-1:0] out_worker_reg, out_worker_next;
    logic [TIME_W-1:0]   out_time_reg, out_time_next;

    // RAM ports
    logic              t_we;
    logic [AW-1:0]     t_waddr, t_raddr;
    logic [TIME_W-1:0] t_wdata, t_rdata;
    logic              l_we;
    logic [AW-1:0]     l_waddr, l_raddr;
    logic [LW-1:0]     l_wdata, l_rdata;

    logic stop_here;

    erwq_ram #(
        .WIDTH (TIME_W),
        .DEPTH (NUM_WORKERS)
    ) u_time_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    erwq_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_WORKERS)
    ) u_link_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else if (cfg_we)
        begin
            start_reg <= cfg_wdata;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sweep_val_reg <= '0;
            sweep_idx_reg <= '0;
            init_out_reg  <= 1'b0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_val_reg <= sweep_val_next;
            sweep_idx_reg <= sweep_idx_next;
            init_out_reg  <= init_out_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Walk and result payload
    always_ff @(posedge clk)
    begin
        when_reg       <= when_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        hsucc_reg      <= hsucc_next;
        out_worker_reg <= out_worker_next;
        out_time_reg   <= out_time_next;
    end

    // Stop before a worker that is later, or equal and numbered above the head
    assign stop_here = (t_rdata > when_reg) ||
                       ((t_rdata == when_reg) && (cur_reg > {1'b0, head_reg}));

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        sweep_val_next  = sweep_val_reg;
        sweep_idx_next  = sweep_idx_reg;
        init_out_next   = init_out_reg;
        head_next       = head_reg;
        when_next       = when_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        hsucc_next      = hsucc_reg;
        out_worker_next = out_worker_reg;
        out_time_next   = out_time_reg;
        out_valid_next  = out_valid_reg;

        t_we    = 1'b0;
        t_waddr = head_reg;
        t_wdata = when_reg;
        t_raddr = head_reg;
        l_we    = 1'b0;
        l_waddr = head_reg;
        l_wdata = cur_reg;
        l_raddr = head_reg;

        s_tready = 1'b0;

        // drop the result once taken
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                t_we    = 1'b1;
                t_waddr = sweep_idx_reg;
                t_wdata = sweep_val_reg;
                l_we    = 1'b1;
                l_waddr = sweep_idx_reg;
                l_wdata = (sweep_idx_reg == LAST_IDX) ? LINK_NULL
                                                      : LW'({1'b0, sweep_idx_reg}) + LW'(1);
                sweep_idx_next = sweep_idx_reg + AW'(1);
                if (sweep_idx_reg == LAST_IDX)
                begin
                    sweep_idx_next = '0;
                    head_next      = '0;
                    state_next     = init_out_reg ? ST_HREAD : ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser[0] == KIND_INIT)
                    begin
                        sweep_val_next = start_reg;
                        sweep_idx_next = '0;
                        init_out_next  = 1'b1;
                        state_next     = ST_CLEAR;
                    end
                    else
                    begin
                        // rewrite the head's time, fetch its successor
                        t_we       = 1'b1;
                        t_waddr    = head_reg;
                        t_wdata    = s_tdata;
                        l_raddr    = head_reg;
                        when_next  = s_tdata;
                        state_next = ST_HLINK;
                    end
                end
            end

            ST_HLINK:
            begin
                hsucc_next = l_rdata;
                cur_next   = l_rdata;
                prev_next  = LINK_NULL;
                t_raddr    = l_rdata[AW-1:0];
                l_raddr    = l_rdata[AW-1:0];
                state_next = (l_rdata >= LINK_NULL) ? ST_HREAD : ST_CMP;
            end

            ST_CMP:
            begin
                if (stop_here)
                begin
                    state_next = (prev_reg == LINK_NULL) ? ST_HREAD : ST_LPREV;
                end
                else
                begin
                    // advance one link, read the next worker at once
                    prev_next = cur_reg;
                    cur_next  = (l_rdata >= LINK_NULL) ? LINK_NULL : l_rdata;
                    t_raddr   = l_rdata[AW-1:0];
                    l_raddr   = l_rdata[AW-1:0];
                    if (l_rdata >= LINK_NULL)
                    begin
                        state_next = ST_LPREV;
                    end
                end
            end

            ST_LPREV:
            begin
                l_we       = 1'b1;
                l_waddr    = prev_reg[AW-1:0];
                l_wdata    = {1'b0, head_reg};
                state_next = ST_LHEAD;
            end

            ST_LHEAD:
            begin
                l_we       = 1'b1;
                l_waddr    = head_reg;
                l_wdata    = cur_reg;
                head_next  = hsucc_reg[AW-1:0];
                state_next = ST_HREAD;
            end

            ST_HREAD:
            begin
                t_raddr    = head_reg;
                state_next = ST_HOUT;
            end

            ST_HOUT:
            begin
                // hold the read address so the data stays put
                t_raddr = head_reg;
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_worker_next = WORKER_W'(head_reg);
                    out_time_next   = t_rdata;
                    init_out_next   = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_time_reg, out_worker_reg};

endmodule
